// ----- sv/selection_sorter_core_defines.svh -----
// Assertion helpers for the selection sorter core
`ifndef SELECTION_SORTER_CORE_DEFINES_SVH
`define SELECTION_SORTER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define SSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("selection sorter check failed");

// next-cycle implication, held off during reset
`define SSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("selection sorter check failed");

`endif

// ----- sv/selsort_pkg.sv -----
package selsort_pkg;

    localparam int DEPTH_DEF = 16;

    typedef struct packed {
        logic store;
        logic rd;
        logic take_first;
        logic compare;
        logic emit;
        logic last;
        logic ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/selsort_ctrl.sv -----
`include "selection_sorter_core_defines.svh"

module selsort_ctrl
    import selsort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_last_in,
    output logic                     o_stall,
    input  t_dp_status               i_status,
    output t_dp_cmd                  o_cmd,
    output logic [$clog2(DEPTH)-1:0] o_addr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_first, n_first;
    logic          accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_first = r_first;
        o_cmd   = '0;
        o_addr  = r_cnt[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_cnt < CW'(DEPTH)) begin
                        o_cmd.store = 1'b1;
                        o_addr      = r_cnt[AW-1:0];
                        n_cnt       = CW'(r_cnt + 1'b1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_in) begin
                        n_n     = n_cnt;
                        n_i     = '0;
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                o_cmd.rd = 1'b1;
                o_addr   = r_i[AW-1:0];
                n_j      = CW'(r_i + 1'b1);
                n_first  = 1'b1;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.take_first = r_first;
                o_cmd.compare    = !r_first;
                n_first          = 1'b0;
                if (r_j < r_n) begin
                    o_cmd.rd = 1'b1;
                    o_addr   = r_j[AW-1:0];
                    n_j      = CW'(r_j + 1'b1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ovf  = r_drop;
                    o_cmd.last = (CW'(r_i + 1'b1) == r_n);
                    if (o_cmd.last) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = CW'(r_i + 1'b1);
                        n_state = S_FIRST;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_first <= n_first;
        end
    end

    `SSC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH))
    `SSC_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_j <= r_n && r_i < r_n)
    `SSC_ASSERT_NXT(a_list_done, i_clk, i_rst_n, o_cmd.emit && o_cmd.last,
                    r_state == S_IDLE && r_cnt == '0 && !r_drop)

endmodule

// ----- sv/selsort_dp.sv -----
`include "selection_sorter_core_defines.svh"

module selsort_dp
    import selsort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_data,
    input  logic signed [31:0]       i_key,
    input  t_dp_cmd                  i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output t_dp_status               o_status,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [31:0]       o_sorted_key,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    localparam int AW = $clog2(DEPTH);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [AW-1:0]      r_rd_idx;
    logic signed [31:0] r_first_val;
    logic signed [31:0] r_sel_val;
    logic [AW-1:0]      r_sel_idx;
    logic               r_desc;
    logic               r_out_valid;
    logic signed [31:0] r_out_key;
    logic               r_out_last;
    logic               r_out_ovf;
    logic               wins;

    assign wins = r_desc ? (r_rd_data > r_sel_val) : (r_rd_data < r_sel_val);

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_sorted_key      = r_out_key;
    assign o_last_out        = r_out_last;
    assign o_overflow        = r_out_ovf;

    // key store; the swap puts the old head into the slot of the winner
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[i_addr] <= i_key;
        end else if (i_cmd.emit) begin
            mem[r_sel_idx] <= r_first_val;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[i_addr];
            r_rd_idx  <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_first) begin
            r_first_val <= r_rd_data;
            r_sel_val   <= r_rd_data;
            r_sel_idx   <= r_rd_idx;
        end else if (i_cmd.compare && wins) begin
            r_sel_val <= r_rd_data;
            r_sel_idx <= r_rd_idx;
        end
        if (i_cmd.emit) begin
            r_out_key  <= r_sel_val;
            r_out_last <= i_cmd.last;
            r_out_ovf  <= i_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SSC_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || !i_stall)
    `SSC_ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, r_out_valid)
    `SSC_ASSERT_IMP(a_one_port, i_clk, i_rst_n, i_cmd.store, !i_cmd.emit && !i_cmd.rd)

endmodule

// ----- sv/selection_sorter_core.sv -----
// Each sort pass reads the head key, then scans the remaining stored keys with one scan
// step per cycle on the single read port of the key store, then emits the winner and
// swaps the old head into its slot, waiting while the output is stalled.
// New keys are refused (o_stall) from the marked key until the whole list is emitted.
// Synchronous active-low reset clears control, counts and the order register;
// the key store is not cleared.
module selection_sorter_core
    import selsort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_key,
    input  logic               i_last_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_sorted_key,
    output logic               o_last_out,
    output logic               o_overflow
);

    localparam int AW = $clog2(DEPTH);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [AW-1:0] addr;

    selsort_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last_in(i_last_in),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_addr   (addr)
    );

    selsort_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_key       (i_key),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .o_status    (status),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sorted_key(o_sorted_key),
        .o_last_out  (o_last_out),
        .o_overflow  (o_overflow)
    );

endmodule

// ----- verif/tb_selection_sorter_core.sv -----
`timescale 1ns / 1ps

module tb_selection_sorter_core;
    import selsort_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int ITEMS_TARGET = 370;
    localparam int LONG_HOLD = 600;
    localparam int SETTLE = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    localparam logic ORDER_ASC = 1'b0;
    localparam logic ORDER_DESC = 1'b1;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] key;
        logic               last;
    } list_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic               last;
        logic               ovf;
    } sorted_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_data = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_key = '0;
    logic               i_last_in = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_sorted_key;
    logic               o_last_out;
    logic               o_overflow;

    // list model
    logic signed [31:0] list_keys [DEPTH];
    int                 list_fill = 0;
    logic               list_dropped = 1'b0;
    logic               sort_desc = ORDER_ASC;

    list_item_t   pending_items [$];
    sorted_word_t sorted_due [$];

    int  items_sent = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_req = 0;
    int  hold_done = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    selection_sorter_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key        (i_key),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sorted_key (o_sorted_key),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit goes_first(logic signed [31:0] a, logic signed [31:0] b);
        return (sort_desc == ORDER_DESC) ? (a > b) : (a < b);
    endfunction

    // store one key; on the marked key sort the list and queue the sorted words
    function automatic void store_key(logic signed [31:0] key, logic last);
        logic signed [31:0] keys [DEPTH];
        logic signed [31:0] tmp;
        int                 sel;
        sorted_word_t       word;
        if (list_fill < DEPTH) begin
            list_keys[list_fill] = key;
            list_fill++;
        end else begin
            list_dropped = 1'b1;
        end
        if (last) begin
            keys = list_keys;
            for (int i = 0; i + 1 < list_fill; i++) begin
                sel = i;
                for (int j = i + 1; j < list_fill; j++) begin
                    if (goes_first(keys[j], keys[sel])) sel = j;
                end
                tmp = keys[i];
                keys[i] = keys[sel];
                keys[sel] = tmp;
            end
            for (int k = 0; k < list_fill; k++) begin
                word.key = keys[k];
                word.last = (k + 1 == list_fill);
                word.ovf = list_dropped;
                sorted_due.push_back(word);
            end
            list_fill = 0;
            list_dropped = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return int'($urandom_range(0, 8)) - 4;
            3: return {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return DEPTH;
        if (r < 18) return $urandom_range(DEPTH + 1, DEPTH + 5);
        if (r < 28) return 1;
        return $urandom_range(2, 12);
    endfunction

    task automatic push_item(logic signed [31:0] key, logic last);
        list_item_t item;
        item.key = key;
        item.last = last;
        pending_items.push_back(item);
        items_sent++;
    endtask

    task automatic push_list(int len);
        for (int k = 0; k < len; k++) push_item(rand_key(), k == len - 1);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || sorted_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_order(logic desc);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= desc;
        sort_desc = desc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // input driver
    always @(posedge i_clk) begin
        list_item_t item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                store_key(i_key, i_last_in);
                gap_left = pick_gap();
            end
            if (gap_left != 0 || pending_items.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                item = pending_items.pop_front();
                i_valid <= 1'b1;
                i_key <= item.key;
                i_last_in <= item.last;
            end
        end
    end

    // output monitor and stall generator
    always @(posedge i_clk) begin
        sorted_word_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (sorted_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected transfer: key %0d last %0b ovf %0b",
                                 o_sorted_key, o_last_out, o_overflow);
                end else begin
                    want = sorted_due.pop_front();
                    if (o_sorted_key !== want.key || o_last_out !== want.last ||
                        o_overflow !== want.ovf) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: exp key %0d last %0b ovf %0b, got key %0d last %0b ovf %0b",
                                     want.key, want.last, want.ovf,
                                     o_sorted_key, o_last_out, o_overflow);
                    end
                end
                stall_left = pick_gap();
            end
            if (hold_req != hold_done) begin
                hold_done++;
                stall_left = LONG_HOLD;
            end
            i_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n_lists;
        logic desc;
        phase = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single key, extremes with ties, overflow dropping the marked key
        push_item(KEY_MIN, 1'b1);
        push_item(KEY_MAX, 1'b0);
        push_item(KEY_MIN, 1'b0);
        push_item(32'sd0, 1'b0);
        push_item(-32'sd1, 1'b0);
        push_item(32'sd1, 1'b0);
        push_item(KEY_MAX, 1'b0);
        push_item(-32'sd1, 1'b1);
        push_list(DEPTH + 1);
        wait_drained();

        while (items_sent < ITEMS_TARGET) begin
            if (phase == 0) desc = ORDER_DESC;
            else if (phase == 1) desc = ORDER_ASC;
            else desc = $urandom_range(0, 1);
            set_order(desc);
            calm <= ($urandom_range(0, 3) == 0);
            if (phase == 2) hold_req <= hold_req + 1;
            n_lists = $urandom_range(4, 8);
            repeat (n_lists) push_list(rand_len());
            wait_drained();
            phase++;
        end

        mismatches += sorted_due.size();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/selsort_pkg.sv
sv/selsort_ctrl.sv
sv/selsort_dp.sv
sv/selection_sorter_core.sv
verif/tb_selection_sorter_core.sv
